[rtl/dfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared widths and register codes for the delimiter field splitter.
// ----------------------------------------------------------------------------
package dfs_pkg;

   localparam int BYTE_W      = 8;
   localparam int DELIM_LEN_W = 4;
   localparam int DELIM_W     = 64;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELIM_LEN   = 1'b0,
      CSR_DELIM_BYTES = 1'b1
   } csr_index_type;

   localparam logic [DELIM_LEN_W-1:0] DELIM_LEN_RESET   = 4'd1;
   localparam logic [DELIM_W-1:0]     DELIM_BYTES_RESET = 64'd44;

endpackage

[rtl/delimiter_field_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_field_splitter
// Splits a byte stream into fields at a configurable multi-byte delimiter.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one byte per item with req_last_byte on the final byte of a
//   string. rsp_* gives zero or more results per item, each a field byte
//   (rsp_byte_valid) or an end-of-field marker (rsp_field_end), rsp_run_last
//   on the final result caused by an input item. csr_* writes delim_len
//   (index 0) and delim_bytes (index 1); write only while no item is in flight.
//   Bytes are held in a window as long as the delimiter; a full window that
//   matches is swallowed and gives one end-of-field result.
// Timing and throughput:
//   a result is registered into the output register by the step that makes
//   it; the first step runs once the pending flag set at acceptance is
//   registered. One result leaves per cycle while rsp_ready stays high, so
//   ordinary bytes stream at one item per cycle. A last byte occupies the
//   step unit through the window flush and the closing marker; a length cut
//   mid-string also holds it for each extra result.
// Reset clears the window fill, field state, pending step and output valid;
// the delimiter returns to a single comma. When rsp_ready is low the output
// register holds its result and req_ready drops once the step unit has a result to give.
// ----------------------------------------------------------------------------
module delimiter_field_splitter #(
   parameter int MAX_DELIM_LEN = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dfs_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dfs_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_field_end,
   output logic                            rsp_run_last,
   input  logic                            csr_write_en,
   input  logic [dfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FW     = $clog2(MAX_DELIM_LEN + 1);
   localparam int NBYTES = (MAX_DELIM_LEN > 8) ? MAX_DELIM_LEN : 8;
   localparam int PADW   = NBYTES * dfs_pkg::BYTE_W;

   logic [dfs_pkg::DELIM_LEN_W-1:0] delim_len_ff;
   logic [dfs_pkg::DELIM_W-1:0]     delim_bytes_ff;

   logic [dfs_pkg::BYTE_W-1:0] win_ff [MAX_DELIM_LEN];
   logic [dfs_pkg::BYTE_W-1:0] win_in [MAX_DELIM_LEN];
   logic [FW-1:0]              fill_ff, fill_in;
   logic                       hd_ff, hd_in;
   logic                       pend_ff, pend_in;
   logic                       pend_last_ff, pend_last_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dfs_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                       rsp_bv_ff, rsp_bv_in;
   logic                       rsp_fe_ff, rsp_fe_in;
   logic                       rsp_rl_ff, rsp_rl_in;

   logic [FW-1:0]   len_act;
   logic [PADW-1:0] delim_pad;
   logic            hit;
   logic            has_res;
   logic            step_final;
   logic            advance;
   logic            out_space;
   logic            accept;
   logic [FW-1:0]   nfill;
   logic            nhd;
   logic [FW-1:0]   shift;
   logic [dfs_pkg::BYTE_W-1:0] step_byte;
   logic            step_bv;
   logic            step_fe;
   logic [FW-1:0]   post_fill;
   logic [dfs_pkg::BYTE_W-1:0] shifted [MAX_DELIM_LEN];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_len_ff   <= dfs_pkg::DELIM_LEN_RESET;
         delim_bytes_ff <= dfs_pkg::DELIM_BYTES_RESET;
      end else if (csr_write_en) begin
         unique case (dfs_pkg::csr_index_type'(csr_index))
            dfs_pkg::CSR_DELIM_LEN: begin
               delim_len_ff <= csr_wdata[dfs_pkg::DELIM_LEN_W-1:0];
            end
            dfs_pkg::CSR_DELIM_BYTES: begin
               delim_bytes_ff <= csr_wdata[dfs_pkg::DELIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective length: zero reads as one, saturate at the window depth
   always_comb begin
      if (delim_len_ff == '0) begin
         len_act = FW'(1);
      end else if (int'(delim_len_ff) > MAX_DELIM_LEN) begin
         len_act = FW'(MAX_DELIM_LEN);
      end else begin
         len_act = FW'(delim_len_ff);
      end
   end

   assign delim_pad = PADW'(delim_bytes_ff);

   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         if (i < int'(len_act) &&
             win_ff[i] != delim_pad[dfs_pkg::BYTE_W*i +: dfs_pkg::BYTE_W]) begin
            hit = 1'b0;
         end
      end
   end

   // one step of the split loop or of the end-of-string flush
   always_comb begin
      has_res   = 1'b0;
      nfill     = fill_ff;
      nhd       = hd_ff;
      shift     = '0;
      step_byte = '0;
      step_bv   = 1'b0;
      step_fe   = 1'b0;
      if (pend_ff) begin
         if (fill_ff >= len_act) begin
            has_res = 1'b1;
            if (hit) begin
               step_fe = 1'b1;
               shift   = len_act;
               nfill   = fill_ff - len_act;
               nhd     = 1'b0;
            end else begin
               step_byte = win_ff[0];
               step_bv   = 1'b1;
               shift     = FW'(1);
               nfill     = fill_ff - FW'(1);
               nhd       = 1'b1;
            end
         end else if (pend_last_ff && fill_ff != '0) begin
            has_res   = 1'b1;
            step_byte = win_ff[0];
            step_bv   = 1'b1;
            shift     = FW'(1);
            nfill     = fill_ff - FW'(1);
            nhd       = 1'b1;
         end else if (pend_last_ff && hd_ff) begin
            has_res = 1'b1;
            step_fe = 1'b1;
            nhd     = 1'b0;
         end
      end
   end

   assign step_final = !has_res ||
                       (nfill < len_act &&
                        (!pend_last_ff || (nfill == '0 && !nhd)));
   assign out_space  = !rsp_valid_ff || rsp_ready;
   assign advance    = pend_ff && (!has_res || out_space);
   assign req_ready  = !pend_ff || (advance && step_final);
   assign accept     = req_valid && req_ready;
   assign post_fill  = advance ? nfill : fill_ff;

   always_comb begin
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         shifted[i] = win_ff[i];
         for (int j = 0; j < MAX_DELIM_LEN; j++) begin
            if (j == i + int'(shift)) begin
               shifted[i] = win_ff[j];
            end
         end
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      hd_in        = hd_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         win_in[i] = advance ? shifted[i] : win_ff[i];
      end
      if (advance) begin
         fill_in = nfill;
         hd_in   = nhd;
         if (step_final) begin
            pend_in = 1'b0;
         end
      end
      if (accept) begin
         pend_in      = 1'b1;
         pend_last_in = req_last_byte;
         fill_in      = post_fill + FW'(1);
         for (int i = 0; i < MAX_DELIM_LEN; i++) begin
            if (i == int'(post_fill)) begin
               win_in[i] = req_data_byte;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_fe_in    = rsp_fe_ff;
      rsp_rl_in    = rsp_rl_ff;
      if (advance && has_res) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = step_byte;
         rsp_bv_in    = step_bv;
         rsp_fe_in    = step_fe;
         rsp_rl_in    = step_final;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         hd_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         hd_ff        <= hd_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         win_ff[i] <= win_in[i];
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_bv_ff   <= rsp_bv_in;
      rsp_fe_ff   <= rsp_fe_in;
      rsp_rl_ff   <= rsp_rl_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bv_ff;
   assign rsp_field_end  = rsp_fe_ff;
   assign rsp_run_last   = rsp_rl_ff;

   // a marker never carries a byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_end |-> !rsp_byte_valid && rsp_out_byte == '0)
      else $error("field end result carries byte data");

   // between items the window is never filled to its full depth
   assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> fill_ff < len_act || fill_ff < FW'(MAX_DELIM_LEN))
      else $error("window overfull while idle");

   // an accepted item always leaves the step unit with work
   assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff && fill_ff != '0)
      else $error("accepted item not pending");

   // end of string leaves a clean state
   assert property (@(posedge clock) disable iff (reset)
      advance && step_final && pend_last_ff && !accept |=> fill_ff == '0 && !hd_ff)
      else $error("state not cleared after end of string");

endmodule
